### rtl/core/ghtrp_pkg.sv
// Shared types, codes and defaults for the grid heading tracker return path.
`default_nettype none

package ghtrp_pkg;

    localparam int COORD_MAX_DEF = 16;

    localparam logic [2:0] OP_FWD   = 3'd0;
    localparam logic [2:0] OP_LEFT  = 3'd1;
    localparam logic [2:0] OP_RIGHT = 3'd2;
    localparam logic [2:0] OP_STOP  = 3'd3;
    localparam logic [2:0] OP_SET   = 3'd4;
    localparam logic [2:0] OP_RET   = 3'd5;

    localparam logic [1:0] HD_EAST  = 2'd0;
    localparam logic [1:0] HD_NORTH = 2'd1;
    localparam logic [1:0] HD_WEST  = 2'd2;
    localparam logic [1:0] HD_SOUTH = 2'd3;

    localparam logic [1:0] MV_NONE  = 2'd0;
    localparam logic [1:0] MV_FWD   = 2'd1;
    localparam logic [1:0] MV_LEFT  = 2'd2;
    localparam logic [1:0] MV_RIGHT = 2'd3;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_STOP  = 2'd1;
    localparam logic [1:0] ST_SAT   = 2'd2;

    typedef struct packed {
        logic [2:0] op;
        logic [1:0] hd;
    } t_cmd;

    typedef struct packed {
        logic [1:0]        move_code;
        logic [1:0]        status;
        logic signed [5:0] row_pos;
        logic signed [5:0] col_pos;
        logic [1:0]        heading;
        logic              last;
        logic [6:0]        path_length;
    } t_res;

endpackage

`default_nettype wire

### rtl/core/grid_heading_tracker_return_path_core.sv
// Top level of the grid heading tracker with return-to-origin path generation.
// Commands enter through a queue-like port: a transfer happens when push is high
// and full is low. Results leave the same way: the oldest result sits on the
// o_ ports while empty is low, and a transfer happens when pop is high there.
// A command waits in a two-entry command queue, the back end executes it and
// writes results into a two-entry result queue; a command is registered in the
// command queue, its results in the result queue, which drives the o_ ports.
// Forward, turn, stop and set heading give one result each and the back end
// takes one command per cycle. Return to origin gives one path step per cycle,
// up to 2 * COORD_MAX + 3 steps, or one result when already at the origin; the
// command queue fills behind it and full holds the sender off. Ops 6 and 7 are
// taken and dropped. The back end's one-result-per-cycle executor sets the rate.
// Synchronous reset empties both queues and puts the pose at the origin facing
// east. When the receiver stops popping, the result queue fills, the back end
// holds its command, and after the command queue fills full rises.
`default_nettype none

module grid_heading_tracker_return_path_core #(
    parameter int COORD_MAX = ghtrp_pkg::COORD_MAX_DEF
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              push,
    output logic                   full,
    input  wire logic [2:0]        i_op,
    input  wire logic [1:0]        i_new_heading,
    output logic                   empty,
    input  wire logic              pop,
    output logic [1:0]             o_move_code,
    output logic [1:0]             o_status,
    output logic signed [5:0]      o_row_pos,
    output logic signed [5:0]      o_col_pos,
    output logic [1:0]             o_heading,
    output logic                   o_last,
    output logic [6:0]             o_path_length
);
    import ghtrp_pkg::*;

    t_cmd w_cmd;
    logic w_cmd_valid;
    logic w_cmd_take;
    t_res w_res_in;
    t_res w_res_out;
    logic w_res_wr;
    logic w_res_full;

    ghtrp_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .o_full      (full),
        .i_op        (i_op),
        .i_hd        (i_new_heading),
        .o_cmd_valid (w_cmd_valid),
        .o_cmd       (w_cmd),
        .i_cmd_take  (w_cmd_take)
    );

    ghtrp_back #(
        .COORD_MAX (COORD_MAX)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (w_cmd_valid),
        .i_cmd       (w_cmd),
        .o_cmd_take  (w_cmd_take),
        .i_res_full  (w_res_full),
        .o_res_wr    (w_res_wr),
        .o_res       (w_res_in)
    );

    ghtrp_outq u_outq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (w_res_wr),
        .i_res   (w_res_in),
        .o_full  (w_res_full),
        .o_empty (empty),
        .i_pop   (pop),
        .o_res   (w_res_out)
    );

    assign o_move_code   = w_res_out.move_code;
    assign o_status      = w_res_out.status;
    assign o_row_pos     = w_res_out.row_pos;
    assign o_col_pos     = w_res_out.col_pos;
    assign o_heading     = w_res_out.heading;
    assign o_last        = w_res_out.last;
    assign o_path_length = w_res_out.path_length;

endmodule

`default_nettype wire

### rtl/core/ghtrp_front.sv
// Front end: accepts commands, drops undefined ops and queues the rest.
`default_nettype none

module ghtrp_front (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_push,
    output logic               o_full,
    input  wire logic [2:0]    i_op,
    input  wire logic [1:0]    i_hd,
    output logic               o_cmd_valid,
    output ghtrp_pkg::t_cmd    o_cmd,
    input  wire logic          i_cmd_take
);
    import ghtrp_pkg::*;

    t_cmd       r_mem [2];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;
    logic       n_wr;
    logic       n_rd;
    logic       w_legal;

    always_comb begin
        w_legal = i_op inside {[OP_FWD:OP_RET]};
        n_wr    = i_push && !o_full && w_legal;
        n_rd    = i_cmd_take && o_cmd_valid;
    end

    assign o_full      = (r_cnt == 2'd2);
    assign o_cmd_valid = (r_cnt != 2'd0);
    assign o_cmd       = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (n_wr) begin
                r_wp <= ~r_wp;
            end
            if (n_rd) begin
                r_rp <= ~r_rp;
            end
            if (n_wr && !n_rd) begin
                r_cnt <= r_cnt + 2'd1;
            end else if (!n_wr && n_rd) begin
                r_cnt <= r_cnt - 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (n_wr) begin
            r_mem[r_wp] <= '{op: i_op, hd: i_hd};
        end
    end

`ifndef ASSERT_OFF
    a_no_overfill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt != 2'd3))
        else $error("command queue count out of range");
    a_drop_undef: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_push && !o_full && (i_op > OP_RET) && !n_rd)
        |=> $stable(r_cnt))
        else $error("undefined op entered the command queue");
    a_valid_head: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd_valid |-> (o_cmd.op <= OP_RET))
        else $error("undefined op at queue head");
`endif

endmodule

`default_nettype wire

### rtl/core/ghtrp_back.sv
// Back end: keeps the pose and carries out commands, one result per cycle while the result queue has room.
`default_nettype none

module ghtrp_back #(
    parameter int COORD_MAX = ghtrp_pkg::COORD_MAX_DEF
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_cmd_valid,
    input  wire ghtrp_pkg::t_cmd i_cmd,
    output logic               o_cmd_take,
    input  wire logic          i_res_full,
    output logic               o_res_wr,
    output ghtrp_pkg::t_res    o_res
);
    import ghtrp_pkg::*;

    localparam logic signed [5:0] LIM  = 6'(COORD_MAX);
    localparam logic signed [5:0] NLIM = -LIM;

    logic signed [5:0] r_row;
    logic signed [5:0] r_col;
    logic [1:0]        r_hd;
    logic [6:0]        r_len;
    logic signed [5:0] n_row;
    logic signed [5:0] n_col;
    logic [1:0]        n_hd;
    logic [6:0]        n_len;
    logic signed [5:0] w_frow;
    logic signed [5:0] w_fcol;
    logic              w_sat;
    logic              w_go;
    logic              w_home;
    logic              w_fhome;
    logic [1:0]        w_tgt;
    logic [1:0]        w_diff;
    logic [6:0]        w_len_inc;
    logic [1:0]        w_move;
    logic [1:0]        w_status;
    logic              w_last;
    logic [6:0]        w_plen;

    always_comb begin
        w_frow = r_row;
        w_fcol = r_col;
        case (r_hd)
            HD_EAST:  w_fcol = r_col + 6'sd1;
            HD_NORTH: w_frow = r_row + 6'sd1;
            HD_WEST:  w_fcol = r_col - 6'sd1;
            default:  w_frow = r_row - 6'sd1;
        endcase
        w_sat = (w_frow > LIM) || (w_frow < NLIM) || (w_fcol > LIM) || (w_fcol < NLIM);
        w_home  = (r_row == 6'sd0) && (r_col == 6'sd0);
        w_fhome = (w_frow == 6'sd0) && (w_fcol == 6'sd0);
        if (r_row != 6'sd0) begin
            w_tgt = (r_row > 6'sd0) ? HD_SOUTH : HD_NORTH;
        end else begin
            w_tgt = (r_col > 6'sd0) ? HD_WEST : HD_EAST;
        end
        w_diff    = w_tgt - r_hd;
        w_len_inc = r_len + 7'd1;
        w_go      = i_cmd_valid && !i_res_full;

        n_row      = r_row;
        n_col      = r_col;
        n_hd       = r_hd;
        n_len      = r_len;
        w_move     = MV_NONE;
        w_status   = ST_OK;
        w_last     = 1'b1;
        w_plen     = 7'd0;
        o_cmd_take = 1'b0;
        o_res_wr   = 1'b0;

        if (w_go) begin
            o_cmd_take = 1'b1;
            o_res_wr   = 1'b1;
            case (i_cmd.op)
                OP_FWD: begin
                    if (w_sat) begin
                        w_status = ST_SAT;
                    end else begin
                        n_row = w_frow;
                        n_col = w_fcol;
                    end
                end
                OP_LEFT:  n_hd = r_hd + 2'd1;
                OP_RIGHT: n_hd = r_hd - 2'd1;
                OP_STOP:  w_status = ST_STOP;
                OP_SET:   n_hd = i_cmd.hd;
                OP_RET: begin
                    if (!w_home) begin
                        if (w_diff == 2'd0) begin
                            w_move = MV_FWD;
                            n_row  = w_frow;
                            n_col  = w_fcol;
                            w_last = w_fhome;
                        end else if (w_diff == 2'd1) begin
                            w_move = MV_LEFT;
                            n_hd   = r_hd + 2'd1;
                            w_last = 1'b0;
                        end else begin
                            w_move = MV_RIGHT;
                            n_hd   = r_hd - 2'd1;
                            w_last = 1'b0;
                        end
                        o_cmd_take = w_last;
                        w_plen     = w_last ? w_len_inc : 7'd0;
                        n_len      = w_last ? 7'd0 : w_len_inc;
                    end
                end
                default: o_res_wr = 1'b0;
            endcase
        end

        o_res = '{move_code: w_move, status: w_status, row_pos: n_row, col_pos: n_col,
                  heading: n_hd, last: w_last, path_length: w_plen};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row <= 6'sd0;
            r_col <= 6'sd0;
            r_hd  <= HD_EAST;
            r_len <= 7'd0;
        end else begin
            r_row <= n_row;
            r_col <= n_col;
            r_hd  <= n_hd;
            r_len <= n_len;
        end
    end

`ifndef ASSERT_OFF
    a_row_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_row <= LIM) && (r_row >= NLIM) && (r_col <= LIM) && (r_col >= NLIM))
        else $error("pose outside the coordinate limit");
    a_mid_path: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_wr && !o_res.last) |-> (o_res.move_code != MV_NONE && !o_cmd_take))
        else $error("intermediate result without a path step");
    a_last_home: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_wr && o_res.last && o_res.move_code != MV_NONE)
        |-> (o_res.row_pos == 6'sd0 && o_res.col_pos == 6'sd0))
        else $error("return path ended away from the origin");
    a_len_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd_take |=> (r_len == 7'd0))
        else $error("path length not cleared after a command");
`endif

endmodule

`default_nettype wire

### rtl/core/ghtrp_outq.sv
// Two-entry result queue that parts the back end from the result receiver.
`default_nettype none

module ghtrp_outq (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_wr,
    input  wire ghtrp_pkg::t_res i_res,
    output logic               o_full,
    output logic               o_empty,
    input  wire logic          i_pop,
    output ghtrp_pkg::t_res    o_res
);
    import ghtrp_pkg::*;

    t_res       r_mem [2];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;
    logic       n_wr;
    logic       n_rd;

    assign o_full  = (r_cnt == 2'd2);
    assign o_empty = (r_cnt == 2'd0);
    assign o_res   = r_mem[r_rp];
    assign n_wr    = i_wr && !o_full;
    assign n_rd    = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (n_wr) begin
                r_wp <= ~r_wp;
            end
            if (n_rd) begin
                r_rp <= ~r_rp;
            end
            if (n_wr && !n_rd) begin
                r_cnt <= r_cnt + 2'd1;
            end else if (!n_wr && n_rd) begin
                r_cnt <= r_cnt - 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (n_wr) begin
            r_mem[r_wp] <= i_res;
        end
    end

`ifndef ASSERT_OFF
    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt != 2'd3))
        else $error("result queue count out of range");
    a_wr_lost: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_wr && o_full))
        else $error("result written into a full queue");
    a_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (n_wr && o_empty) |=> !o_empty)
        else $error("result queue stayed empty after a write");
`endif

endmodule

`default_nettype wire

### verif/tb_grid_heading_tracker_return_path_core.sv
`timescale 1ns / 100ps
// Self-checking testbench for the grid heading tracker with return-to-origin paths.

module tb_grid_heading_tracker_return_path_core;
    import ghtrp_pkg::*;

    localparam logic [2:0] OP_UNDEF_LO = 3'd6;
    localparam logic [2:0] OP_UNDEF_HI = 3'd7;
    localparam int STALL_LIMIT = 2000;

    class heading_tracker_scoreboard;
        int         row_now;
        int         col_now;
        logic [1:0] facing_now;
        t_res       expected_steps[$];
        int         mismatches;

        function new();
            row_now    = 0;
            col_now    = 0;
            facing_now = HD_EAST;
            mismatches = 0;
        endfunction

        function int pending();
            return expected_steps.size();
        endfunction

        function void log_step(logic [1:0] move, logic [1:0] status);
            t_res r;
            r.move_code   = move;
            r.status      = status;
            r.row_pos     = row_now[5:0];
            r.col_pos     = col_now[5:0];
            r.heading     = facing_now;
            r.last        = 1'b0;
            r.path_length = '0;
            expected_steps.push_back(r);
        endfunction

        function void close_command(int steps);
            t_res tail;
            tail = expected_steps.pop_back();
            tail.last        = 1'b1;
            tail.path_length = steps[6:0];
            expected_steps.push_back(tail);
        endfunction

        function bit try_forward();
            int r;
            int c;
            r = row_now;
            c = col_now;
            case (facing_now)
                HD_EAST:  c = c + 1;
                HD_NORTH: r = r + 1;
                HD_WEST:  c = c - 1;
                default:  r = r - 1;
            endcase
            if (r > COORD_MAX_DEF || r < -COORD_MAX_DEF ||
                c > COORD_MAX_DEF || c < -COORD_MAX_DEF)
                return 1'b0;
            row_now = r;
            col_now = c;
            return 1'b1;
        endfunction

        // A quarter turn counterclockwise is a left turn; a half turn is two rights.
        function int turn_toward(logic [1:0] target);
            logic [1:0] diff;
            diff = target - facing_now;
            if (diff == 2'd0)
                return 0;
            if (diff == 2'd1) begin
                facing_now = facing_now + 2'd1;
                log_step(MV_LEFT, ST_OK);
                return 1;
            end
            facing_now = facing_now - 2'd1;
            log_step(MV_RIGHT, ST_OK);
            if (diff == 2'd3)
                return 1;
            facing_now = facing_now - 2'd1;
            log_step(MV_RIGHT, ST_OK);
            return 2;
        endfunction

        function int walk_home(bit on_row);
            int n;
            n = 0;
            while ((on_row ? row_now : col_now) != 0) begin
                if (!try_forward())
                    break;
                log_step(MV_FWD, ST_OK);
                n++;
            end
            return n;
        endfunction

        function void note_command(logic [2:0] op, logic [1:0] hd);
            int steps;
            bit ok;
            steps = 0;
            case (op)
                OP_FWD: begin
                    ok = try_forward();
                    log_step(MV_NONE, ok ? ST_OK : ST_SAT);
                end
                OP_LEFT: begin
                    facing_now = facing_now + 2'd1;
                    log_step(MV_NONE, ST_OK);
                end
                OP_RIGHT: begin
                    facing_now = facing_now - 2'd1;
                    log_step(MV_NONE, ST_OK);
                end
                OP_STOP: log_step(MV_NONE, ST_STOP);
                OP_SET: begin
                    facing_now = hd;
                    log_step(MV_NONE, ST_OK);
                end
                OP_RET: begin
                    if (row_now != 0) begin
                        steps += turn_toward(row_now > 0 ? HD_SOUTH : HD_NORTH);
                        steps += walk_home(1'b1);
                    end
                    if (col_now != 0) begin
                        steps += turn_toward(col_now > 0 ? HD_WEST : HD_EAST);
                        steps += walk_home(1'b0);
                    end
                    if (steps == 0)
                        log_step(MV_NONE, ST_OK);
                end
                default: return;
            endcase
            close_command(steps);
        endfunction

        function void compare_field(string name, logic signed [31:0] want,
                                    logic signed [31:0] seen);
            if (seen !== want) begin
                $error("%s: expected %0d, actual %0d", name, want, seen);
                mismatches++;
            end
        endfunction

        function void check_result(t_res seen);
            t_res want;
            if (expected_steps.size() == 0) begin
                $error("Result transfer with nothing expected: move_code %0d, status %0d",
                       seen.move_code, seen.status);
                mismatches++;
                return;
            end
            want = expected_steps.pop_front();
            compare_field("move_code", want.move_code, seen.move_code);
            compare_field("status", want.status, seen.status);
            compare_field("row_pos", want.row_pos, seen.row_pos);
            compare_field("col_pos", want.col_pos, seen.col_pos);
            compare_field("heading", want.heading, seen.heading);
            compare_field("last", want.last, seen.last);
            compare_field("path_length", want.path_length, seen.path_length);
        endfunction
    endclass

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              push = 1'b0;
    logic              pop = 1'b0;
    logic [2:0]        i_op = OP_FWD;
    logic [1:0]        i_new_heading = HD_EAST;
    logic              full;
    logic              empty;
    logic [1:0]        o_move_code;
    logic [1:0]        o_status;
    logic signed [5:0] o_row_pos;
    logic signed [5:0] o_col_pos;
    logic [1:0]        o_heading;
    logic              o_last;
    logic [6:0]        o_path_length;

    heading_tracker_scoreboard tracker;
    t_res seen_result;
    int   tx_calm = 0;
    int   rx_calm = 0;
    int   rx_stall = 0;
    int   quiet_cycles = 0;
    int   commands_sent = 0;

    grid_heading_tracker_return_path_core #(
        .COORD_MAX(COORD_MAX_DEF)
    ) i_dut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .push(push),
        .full(full),
        .i_op(i_op),
        .i_new_heading(i_new_heading),
        .empty(empty),
        .pop(pop),
        .o_move_code(o_move_code),
        .o_status(o_status),
        .o_row_pos(o_row_pos),
        .o_col_pos(o_col_pos),
        .o_heading(o_heading),
        .o_last(o_last),
        .o_path_length(o_path_length)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    function automatic int idle_gap();
        if ($urandom_range(0, 9) < 6)
            return 0;
        if ($urandom_range(0, 9) < 8)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    task automatic send(input logic [2:0] op, input logic [1:0] hd);
        int gap;
        gap = 0;
        if (tx_calm > 0) begin
            tx_calm--;
        end else begin
            gap = idle_gap();
            if ($urandom_range(0, 19) == 0)
                tx_calm = $urandom_range(10, 40);
        end
        if (gap > 0) begin
            push <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        push          <= 1'b1;
        i_op          <= op;
        i_new_heading <= hd;
        do @(posedge i_clk); while (full);
        tracker.note_command(op, hd);
        if (op <= OP_RET)
            commands_sent++;
    endtask

    task automatic wait_drained();
        push <= 1'b0;
        do @(posedge i_clk); while (tracker.pending() != 0);
    endtask

    always @(posedge i_clk) begin
        if (rx_stall > 0) begin
            pop <= 1'b0;
            rx_stall--;
        end else begin
            pop <= 1'b1;
            if (rx_calm > 0) begin
                rx_calm--;
            end else begin
                rx_stall = idle_gap();
                if ($urandom_range(0, 19) == 0)
                    rx_calm = $urandom_range(10, 40);
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && pop && !empty) begin
            seen_result.move_code   = o_move_code;
            seen_result.status      = o_status;
            seen_result.row_pos     = o_row_pos;
            seen_result.col_pos     = o_col_pos;
            seen_result.heading     = o_heading;
            seen_result.last        = o_last;
            seen_result.path_length = o_path_length;
            tracker.check_result(seen_result);
        end
        if (!i_rst_n || (push && !full) || (pop && !empty))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    initial begin
        int pick;
        int run;
        tracker = new();
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Return at the origin, then short trips home from two quadrants and an axis.
        send(OP_RET, HD_EAST);
        send(OP_FWD, HD_SOUTH);
        send(OP_LEFT, HD_EAST);
        send(OP_FWD, HD_EAST);
        send(OP_FWD, HD_WEST);
        send(OP_RET, HD_NORTH);
        send(OP_SET, HD_SOUTH);
        send(OP_FWD, HD_EAST);
        send(OP_RIGHT, HD_SOUTH);
        send(OP_FWD, HD_EAST);
        send(OP_RET, HD_WEST);
        send(OP_STOP, HD_SOUTH);
        send(OP_UNDEF_LO, HD_NORTH);
        send(OP_UNDEF_HI, HD_SOUTH);
        send(OP_SET, HD_NORTH);
        send(OP_SET, HD_WEST);
        send(OP_FWD, HD_NORTH);
        send(OP_SET, HD_EAST);
        send(OP_RIGHT, HD_WEST);
        send(OP_LEFT, HD_NORTH);
        send(OP_RET, HD_SOUTH);
        wait_drained();

        // Mostly straight runs on a chosen heading, long enough at times to hit the edge.
        while (commands_sent < 350) begin
            pick = $urandom_range(0, 99);
            if (pick < 40) begin
                send(OP_SET, 2'($urandom_range(HD_EAST, HD_SOUTH)));
                run = ($urandom_range(0, 4) == 0) ? $urandom_range(14, 34)
                                                  : $urandom_range(1, 6);
                repeat (run) send(OP_FWD, 2'($urandom_range(HD_EAST, HD_SOUTH)));
            end else if (pick < 55) begin
                send(OP_RET, 2'($urandom_range(HD_EAST, HD_SOUTH)));
            end else if (pick < 92) begin
                send(3'($urandom_range(OP_FWD, OP_RET)),
                     2'($urandom_range(HD_EAST, HD_SOUTH)));
            end else begin
                send(3'($urandom_range(OP_UNDEF_LO, OP_UNDEF_HI)),
                     2'($urandom_range(HD_EAST, HD_SOUTH)));
            end
            if (pick >= 97)
                wait_drained();
        end

        wait_drained();
        repeat (10) @(posedge i_clk);
        if (tracker.mismatches == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

### filelist.f
rtl/core/ghtrp_pkg.sv
rtl/core/ghtrp_front.sv
rtl/core/ghtrp_back.sv
rtl/core/ghtrp_outq.sv
rtl/core/grid_heading_tracker_return_path_core.sv
verif/tb_grid_heading_tracker_return_path_core.sv
